>>> rtl/tbe_pkg.sv
// ----------------------------------------------------------------------------
// tbe_pkg
// shared types, constants and helpers of the transformed bounds engine
// ----------------------------------------------------------------------------
package tbe_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 12;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 56;
    localparam int OUT_DATA_W = 320;

    localparam logic [CFG_IDX_W-1:0] REG_COL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd5;

    localparam logic [CFG_W-1:0] COL_X_RST = 48'h0000_0000_1000;
    localparam logic [CFG_W-1:0] COL_Y_RST = 48'h0000_1000_0000;
    localparam logic [CFG_W-1:0] COL_Z_RST = 48'h1000_0000_0000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -32'sh8000_0000;

    typedef struct packed {
        logic                             seen;
        logic signed [2:0][COORD_W-1:0]   vmin;
        logic signed [2:0][COORD_W-1:0]   vmax;
    } frame_t;

    typedef struct packed {
        logic [2:0][CFG_W-1:0]          col;
        logic [2:0][COORD_W-1:0]        off;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOX_MUL,
        ST_BOX_ACC,
        ST_BOX_FIN,
        ST_DD_MUL,
        ST_DD_ACC,
        ST_SQH_GO,
        ST_SQH_WAIT,
        ST_CC_MUL,
        ST_CC_ACC,
        ST_SQL_GO,
        ST_SQL_WAIT,
        ST_RAD_MUL,
        ST_RAD,
        ST_DONE
    } back_state_t;

    function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] c,
                                                      input logic [1:0] row);
        logic signed [COEF_W-1:0] v;
        case (row)
            2'd0:    v = c[15:0];
            2'd1:    v = c[31:16];
            2'd2:    v = c[47:32];
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
            input logic signed [ACC_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > ACC_W'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < ACC_W'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/tbe_front.sv
// ----------------------------------------------------------------------------
// tbe_front
// running per-axis min and max of a frame, hands a frame summary on last
// ----------------------------------------------------------------------------
module tbe_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   accept,
    input  logic signed [2:0][tbe_pkg::COORD_W-1:0] pos,
    input  logic                                   has_vertex,
    input  logic                                   last,
    output logic                                   push,
    output tbe_pkg::frame_t                        push_frame
);

    logic signed [2:0][tbe_pkg::COORD_W-1:0] run_min_reg, run_max_reg;
    logic signed [2:0][tbe_pkg::COORD_W-1:0] run_min_next, run_max_next;
    logic                                    seen_reg, seen_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            run_min_next[i] = (has_vertex && $signed(pos[i]) < $signed(run_min_reg[i]))
                              ? pos[i] : run_min_reg[i];
            run_max_next[i] = (has_vertex && $signed(pos[i]) > $signed(run_max_reg[i]))
                              ? pos[i] : run_max_reg[i];
        end
        seen_next = seen_reg | has_vertex;
        push_frame.seen = seen_next;
        push_frame.vmin = run_min_next;
        push_frame.vmax = run_max_next;
        push = accept && last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                run_min_reg[i] <= tbe_pkg::COORD_MAX;
                run_max_reg[i] <= tbe_pkg::COORD_MIN;
            end
            seen_reg <= 1'b0;
        end else if (accept) begin
            if (last) begin
                for (int i = 0; i < 3; i++) begin
                    run_min_reg[i] <= tbe_pkg::COORD_MAX;
                    run_max_reg[i] <= tbe_pkg::COORD_MIN;
                end
                seen_reg <= 1'b0;
            end else begin
                run_min_reg <= run_min_next;
                run_max_reg <= run_max_next;
                seen_reg    <= seen_next;
            end
        end
    end

endmodule

>>> rtl/tbe_queue.sv
// ----------------------------------------------------------------------------
// tbe_queue
// two-entry queue of frame summaries between front and back
// ----------------------------------------------------------------------------
module tbe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tbe_pkg::frame_t push_frame,
    input  logic            pop,
    output tbe_pkg::frame_t pop_frame,
    output logic            empty,
    output logic            full
);

    tbe_pkg::frame_t mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_frame = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("pop from empty queue");

endmodule

>>> rtl/tbe_sqrt.sv
// ----------------------------------------------------------------------------
// tbe_sqrt
// 64-bit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module tbe_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] x_in,
    output logic        busy,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg, r_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [63:0] t;

    assign t    = r_reg + bit_reg;
    assign busy = busy_reg;
    assign done = done_reg;
    assign root = r_reg[31:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= x_in;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (x_reg >= t) begin
                x_reg <= x_reg - t;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("sqrt started while busy");

endmodule

>>> rtl/tbe_back.sv
// ----------------------------------------------------------------------------
// tbe_back
// per-frame sequencer: transform, world box, radius, result register
// ----------------------------------------------------------------------------
module tbe_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tbe_pkg::cfg_t                      cfg,
    input  logic                               q_empty,
    input  tbe_pkg::frame_t                    q_frame,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tbe_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);

    localparam int CF = tbe_pkg::COEF_FRAC;
    localparam int AW = tbe_pkg::ACC_W;

    tbe_pkg::back_state_t st_reg, st_next;
    tbe_pkg::frame_t      fr_reg;
    logic [1:0]           row_reg, row_next, col_reg, col_next;
    logic                 sel_reg, sel_next;

    logic signed [32:0]   mul_a, mul_b;
    logic signed [65:0]   prod_reg;
    logic signed [47:0]   a_reg;
    logic signed [AW-1:0] acc_min_reg, acc_max_reg, acc_sc_reg;
    logic [63:0]          q_reg;
    logic [31:0]          ss_reg, h_reg;
    logic [23:0]          lmax_reg;
    logic signed [2:0][31:0] cen_reg, bmn_reg, bmx_reg;
    logic [30:0]          rad_reg;
    logic                 found_reg;

    logic                 sq_start, sq_busy, sq_done;
    logic [63:0]          sq_x;
    logic [31:0]          sq_root;

    logic                 m_tvalid_reg, m_tuser_reg;
    logic [tbe_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic signed [15:0]   c_cur;
    logic signed [32:0]   d_cur;
    logic signed [47:0]   b_cur;
    logic signed [AW-1:0] sum_min, sum_max, sum_sc;
    logic                 out_free;

    tbe_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x_in    (sq_x),
        .busy    (sq_busy),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign c_cur    = tbe_pkg::coef(cfg.col[col_reg], row_reg);
    assign d_cur    = 33'(signed'(fr_reg.vmax[row_reg])) - 33'(signed'(fr_reg.vmin[row_reg]));
    assign b_cur    = prod_reg[47:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign sum_min  = acc_min_reg + AW'((a_reg < b_cur) ? a_reg : b_cur);
    assign sum_max  = acc_max_reg + AW'((a_reg < b_cur) ? b_cur : a_reg);
    assign sum_sc   = acc_sc_reg + AW'(a_reg) + AW'(b_cur);
    assign sq_x     = (st_reg == tbe_pkg::ST_SQH_GO) ? q_reg : {16'd0, ss_reg, 16'd0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (st_reg)
            tbe_pkg::ST_BOX_MUL: begin
                mul_a = 33'(c_cur);
                mul_b = sel_reg ? 33'(signed'(fr_reg.vmax[col_reg]))
                                : 33'(signed'(fr_reg.vmin[col_reg]));
            end
            tbe_pkg::ST_DD_MUL: begin
                mul_a = d_cur;
                mul_b = d_cur;
            end
            tbe_pkg::ST_CC_MUL: begin
                mul_a = 33'(c_cur);
                mul_b = 33'(c_cur);
            end
            tbe_pkg::ST_RAD_MUL: begin
                mul_a = {1'b0, h_reg};
                mul_b = {9'd0, lmax_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        st_next  = st_reg;
        row_next = row_reg;
        col_next = col_reg;
        sel_next = sel_reg;
        q_pop    = 1'b0;
        sq_start = 1'b0;
        case (st_reg)
            tbe_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    row_next = '0;
                    col_next = '0;
                    sel_next = 1'b0;
                    st_next  = q_frame.seen ? tbe_pkg::ST_BOX_MUL : tbe_pkg::ST_DONE;
                end
            end
            tbe_pkg::ST_BOX_MUL: st_next = tbe_pkg::ST_BOX_ACC;
            tbe_pkg::ST_BOX_ACC: begin
                if (!sel_reg) begin
                    sel_next = 1'b1;
                    st_next  = tbe_pkg::ST_BOX_MUL;
                end else begin
                    sel_next = 1'b0;
                    if (col_reg == 2'd2) begin
                        st_next = tbe_pkg::ST_BOX_FIN;
                    end else begin
                        col_next = col_reg + 2'd1;
                        st_next  = tbe_pkg::ST_BOX_MUL;
                    end
                end
            end
            tbe_pkg::ST_BOX_FIN: begin
                col_next = '0;
                if (row_reg == 2'd2) begin
                    row_next = '0;
                    st_next  = tbe_pkg::ST_DD_MUL;
                end else begin
                    row_next = row_reg + 2'd1;
                    st_next  = tbe_pkg::ST_BOX_MUL;
                end
            end
            tbe_pkg::ST_DD_MUL: st_next = tbe_pkg::ST_DD_ACC;
            tbe_pkg::ST_DD_ACC: begin
                if (row_reg == 2'd2) begin
                    row_next = '0;
                    st_next  = tbe_pkg::ST_SQH_GO;
                end else begin
                    row_next = row_reg + 2'd1;
                    st_next  = tbe_pkg::ST_DD_MUL;
                end
            end
            tbe_pkg::ST_SQH_GO: begin
                sq_start = 1'b1;
                st_next  = tbe_pkg::ST_SQH_WAIT;
            end
            tbe_pkg::ST_SQH_WAIT: begin
                if (sq_done) begin
                    st_next = tbe_pkg::ST_CC_MUL;
                end
            end
            tbe_pkg::ST_CC_MUL: st_next = tbe_pkg::ST_CC_ACC;
            tbe_pkg::ST_CC_ACC: begin
                if (row_reg == 2'd2) begin
                    row_next = '0;
                    st_next  = tbe_pkg::ST_SQL_GO;
                end else begin
                    row_next = row_reg + 2'd1;
                    st_next  = tbe_pkg::ST_CC_MUL;
                end
            end
            tbe_pkg::ST_SQL_GO: begin
                sq_start = 1'b1;
                st_next  = tbe_pkg::ST_SQL_WAIT;
            end
            tbe_pkg::ST_SQL_WAIT: begin
                if (sq_done) begin
                    if (col_reg == 2'd2) begin
                        col_next = '0;
                        st_next  = tbe_pkg::ST_RAD_MUL;
                    end else begin
                        col_next = col_reg + 2'd1;
                        st_next  = tbe_pkg::ST_CC_MUL;
                    end
                end
            end
            tbe_pkg::ST_RAD_MUL: st_next = tbe_pkg::ST_RAD;
            tbe_pkg::ST_RAD:     st_next = tbe_pkg::ST_DONE;
            tbe_pkg::ST_DONE: begin
                if (out_free) begin
                    st_next = tbe_pkg::ST_IDLE;
                end
            end
            default: st_next = tbe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= tbe_pkg::ST_IDLE;
            row_reg <= '0;
            col_reg <= '0;
            sel_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            row_reg <= row_next;
            col_reg <= col_next;
            sel_reg <= sel_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (st_reg)
            tbe_pkg::ST_IDLE: begin
                fr_reg      <= q_frame;
                found_reg   <= q_frame.seen;
                acc_min_reg <= '0;
                acc_max_reg <= '0;
                acc_sc_reg  <= '0;
                q_reg       <= '0;
                ss_reg      <= '0;
                lmax_reg    <= '0;
                cen_reg     <= '0;
                bmn_reg     <= '0;
                bmx_reg     <= '0;
                rad_reg     <= '0;
            end
            tbe_pkg::ST_BOX_ACC: begin
                if (!sel_reg) begin
                    a_reg <= prod_reg[47:0];
                end else begin
                    acc_min_reg <= sum_min;
                    acc_max_reg <= sum_max;
                    acc_sc_reg  <= sum_sc;
                end
            end
            tbe_pkg::ST_BOX_FIN: begin
                cen_reg[row_reg] <= tbe_pkg::sat_coord(
                    ((acc_sc_reg + AW'(64'sd1 <<< CF)) >>> (CF + 1))
                    + AW'(signed'(cfg.off[row_reg])));
                bmn_reg[row_reg] <= tbe_pkg::sat_coord(
                    ((acc_min_reg + AW'(64'sd1 <<< (CF - 1))) >>> CF)
                    + AW'(signed'(cfg.off[row_reg])));
                bmx_reg[row_reg] <= tbe_pkg::sat_coord(
                    ((acc_max_reg + AW'(64'sd1 <<< (CF - 1))) >>> CF)
                    + AW'(signed'(cfg.off[row_reg])));
                acc_min_reg <= '0;
                acc_max_reg <= '0;
                acc_sc_reg  <= '0;
            end
            tbe_pkg::ST_DD_ACC: begin
                q_reg <= q_reg + (64'(prod_reg[63:0]) >> 2);
            end
            tbe_pkg::ST_SQH_WAIT: begin
                if (sq_done) begin
                    h_reg <= sq_root;
                end
            end
            tbe_pkg::ST_CC_ACC: begin
                ss_reg <= ss_reg + prod_reg[31:0];
            end
            tbe_pkg::ST_SQL_WAIT: begin
                if (sq_done) begin
                    ss_reg <= '0;
                    if (sq_root[23:0] > lmax_reg) begin
                        lmax_reg <= sq_root[23:0];
                    end
                end
            end
            tbe_pkg::ST_RAD: begin
                if (((prod_reg[56:0] + 57'(1 << (CF + 7))) >> (CF + 8)) > 57'h7FFF_FFFF) begin
                    rad_reg <= 31'h7FFF_FFFF;
                end else begin
                    rad_reg <= 31'((prod_reg[56:0] + 57'(1 << (CF + 7))) >> (CF + 8));
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (st_reg == tbe_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == tbe_pkg::ST_DONE && out_free) begin
            m_tuser_reg <= found_reg;
            m_tdata_reg <= {1'b0, bmx_reg[2], bmx_reg[1], bmx_reg[0],
                            bmn_reg[2], bmn_reg[1], bmn_reg[0], rad_reg,
                            cen_reg[2], cen_reg[1], cen_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0) else $error("empty frame result not zero");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> st_reg == tbe_pkg::ST_IDLE) else $error("pop outside idle");
    a_sq_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_start |=> sq_busy) else $error("sqrt did not start");

endmodule

>>> rtl/transformed_bounds_engine.sv
// ----------------------------------------------------------------------------
// transformed_bounds_engine
// running vertex bounds with affine transform, world box and bounding radius
// ----------------------------------------------------------------------------
// vertices enter on the s_ channel, one per cycle; tuser is has_vertex and
// tlast closes the frame. the front updates running min and max in the
// accepting cycle and on tlast pushes a frame summary into a two-entry queue.
// the back sequencer works one frame at a time on one shared 33x33 multiplier
// and a two-bit-per-cycle square root unit: multiply and accumulate steps
// plus four roots per frame, from queue pop to the result register load;
// an empty frame skips both. the result sits in an output register on the
// m_ channel until taken. items stream at one per cycle while the queue has
// room; s_tready drops while the queue holds two frames, so a stalled
// receiver backs up into the input after four frames. configuration writes
// on cfg_wen, cfg_idx, cfg_wdata take effect at once; the user must make them
// only while the block is idle; the block does not enforce it. reset clears
// running bounds, queue, sequencer and m_tvalid, restores the identity matrix.
// ----------------------------------------------------------------------------
module transformed_bounds_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [95:0]                         s_tdata,  // pos_x, pos_y, pos_z
    input  logic                                s_tuser,  // has_vertex
    input  logic                                s_tlast,  // last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // center_x, center_y, center_z, radius, box_min_x..z, box_max_x..z, pad
    output logic [tbe_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,  // found
    input  logic                                cfg_wen,
    input  logic [tbe_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [tbe_pkg::CFG_W-1:0]           cfg_wdata
);

    tbe_pkg::cfg_t   cfg_reg;
    tbe_pkg::frame_t push_frame, pop_frame;
    logic            push, pop, q_empty, q_full, accept;
    logic signed [2:0][tbe_pkg::COORD_W-1:0] pos;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign pos[0]   = s_tdata[31:0];
    assign pos[1]   = s_tdata[63:32];
    assign pos[2]   = s_tdata[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.col[0] <= tbe_pkg::COL_X_RST;
            cfg_reg.col[1] <= tbe_pkg::COL_Y_RST;
            cfg_reg.col[2] <= tbe_pkg::COL_Z_RST;
            cfg_reg.off    <= '0;
        end else if (cfg_wen) begin
            case (cfg_idx)
                tbe_pkg::REG_COL_X: cfg_reg.col[0] <= cfg_wdata;
                tbe_pkg::REG_COL_Y: cfg_reg.col[1] <= cfg_wdata;
                tbe_pkg::REG_COL_Z: cfg_reg.col[2] <= cfg_wdata;
                tbe_pkg::REG_OFF_X: cfg_reg.off[0] <= cfg_wdata[31:0];
                tbe_pkg::REG_OFF_Y: cfg_reg.off[1] <= cfg_wdata[31:0];
                tbe_pkg::REG_OFF_Z: cfg_reg.off[2] <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    tbe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .pos        (pos),
        .has_vertex (s_tuser),
        .last       (s_tlast),
        .push       (push),
        .push_frame (push_frame)
    );

    tbe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .empty      (q_empty),
        .full       (q_full)
    );

    tbe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_frame  (pop_frame),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
